/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define KPED_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define KPED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KPED_ASSERT(lbl, clk, rst, prop, msg)
`define KPED_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* src/kped_pkg.sv */
// ---------------------------------------------------------------------------
// kped_pkg
// Types and constants shared by the key press event detector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kped_pkg;

  localparam int KEY_W     = 8;
  localparam int REL_BIT   = 8;   // edge entry: bit 8 set = release
  localparam int EVQ_DEPTH = 4;   // event output queue

  localparam logic [3:0]  DEBOUNCE_RST = 4'd3;
  localparam logic [15:0] LONG_RST     = 16'd40;
  localparam logic [15:0] REPEAT_RST   = 16'd4;
  localparam logic [7:0]  NO_KEY_RST   = 8'd0;

  typedef enum logic [2:0] {
    EV_DOWN   = 3'd0,
    EV_UP     = 3'd1,
    EV_SHORT  = 3'd2,
    EV_LONG   = 3'd3,
    EV_REPEAT = 3'd4
  } ev_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_WAIT_DOWN    = 3'd1,
    PH_WAIT_UP      = 3'd2,
    PH_LONG_CHECK   = 3'd3,
    PH_WAIT_UP2     = 3'd4,
    PH_REPEAT_CHECK = 3'd5,
    PH_FINISH       = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_NO_KEY   = 2'd3
  } cfg_reg_t;

  typedef logic [KEY_W:0] edge_t;

  // optional release (a) and press (b) edge pushes, release first
  typedef struct packed {
    logic  a_en;
    edge_t a;
    logic  b_en;
    edge_t b;
  } push_req_t;

  typedef struct packed {
    logic  avail;  // an entry can be popped this tick
    logic  more;   // another entry remains after that pop
    edge_t head;
  } fifo_stat_t;

  typedef struct packed {
    ev_kind_t         kind;
    logic [KEY_W-1:0] key;
    logic             last;
  } event_t;

  typedef struct packed {
    logic [1:0] cnt;
    event_t     ev0;
    event_t     ev1;
  } evq_wr_t;

endpackage

/* src/kped_edge_fifo.sv */
// ---------------------------------------------------------------------------
// kped_edge_fifo
// Edge event FIFO in two synchronous memory banks with head prefetch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kped_edge_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kped_pkg::push_req_t   push,
  input  logic                  pop,
  output kped_pkg::fifo_stat_t  stat
);
  import kped_pkg::*;

  // slots alternate banks, so the two pushes of one tick never collide
  localparam int PTR_W  = (DEPTH > 4) ? $clog2(DEPTH) : 2;
  localparam int ROW_W  = PTR_W - 1;
  localparam int ROWS   = 2 ** ROW_W;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  edge_t mem0 [ROWS];
  edge_t mem1 [ROWS];

  logic [PTR_W-1:0]  head, tail;
  logic [FILL_W-1:0] fill;
  edge_t             rd0, rd1;
  logic              sel;

  logic              acc_a, acc_b, w0_en, w1_en;
  logic [FILL_W-1:0] fill_a, fill_p, fill_next;
  edge_t             w0_data, w1_data;
  logic [PTR_W-1:0]  tail1, head_next, tail_next;
  logic              we0, we1;
  logic [ROW_W-1:0]  wrow0, wrow1, rrow;
  edge_t             wd0, wd1;

  always_comb begin
    acc_a   = push.a_en && (fill < FILL_MAX);
    fill_a  = fill + FILL_W'(acc_a);
    acc_b   = push.b_en && (fill_a < FILL_MAX);
    fill_p  = fill_a + FILL_W'(acc_b);
    w0_en   = acc_a || acc_b;
    w0_data = acc_a ? push.a : push.b;
    w1_en   = acc_a && acc_b;
    w1_data = push.b;
    tail1   = tail + PTR_W'(1);

    we0   = tail[0] ? w1_en : w0_en;
    wd0   = tail[0] ? w1_data : w0_data;
    wrow0 = tail[0] ? tail1[PTR_W-1:1] : tail[PTR_W-1:1];
    we1   = tail[0] ? w0_en : w1_en;
    wd1   = tail[0] ? w0_data : w1_data;
    wrow1 = tail[0] ? tail[PTR_W-1:1] : tail1[PTR_W-1:1];

    head_next = head + PTR_W'(pop);
    tail_next = tail + PTR_W'(w0_en) + PTR_W'(w1_en);
    fill_next = fill_p - FILL_W'(pop);
    rrow      = head_next[PTR_W-1:1];

    stat.avail = (fill_p != '0);
    stat.more  = (fill_p > FILL_W'(1));
    // empty FIFO: the head is the first entry pushed this tick
    stat.head  = (fill == '0) ? w0_data : (sel ? rd1 : rd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  // write-first read of the next head slot
  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wrow0] <= wd0;
    end
    rd0 <= (we0 && wrow0 == rrow) ? wd0 : mem0[rrow];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wrow1] <= wd1;
    end
    rd1 <= (we1 && wrow1 == rrow) ? wd1 : mem1[rrow];
    sel <= head_next[0];
  end

endmodule

/* src/kped_evt_q.sv */
// ---------------------------------------------------------------------------
// kped_evt_q
// Output event queue: takes up to two events per cycle, sends one while event_ready is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kped_evt_q (
  input  logic              clk,
  input  logic              rst,
  input  kped_pkg::evq_wr_t wr,
  output logic              room,
  output logic              event_valid,
  input  logic              event_ready,
  output kped_pkg::event_t  head
);
  import kped_pkg::*;

  localparam int IDX_W = $clog2(EVQ_DEPTH);
  localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

  event_t           q [EVQ_DEPTH];
  logic [IDX_W-1:0] rp, wp;
  logic [CNT_W-1:0] count;
  logic             rd;

  assign event_valid = (count != '0);
  assign head        = q[rp];
  assign rd          = event_valid && event_ready;
  assign room        = (count <= CNT_W'(EVQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else begin
      rp    <= rp + IDX_W'(rd);
      wp    <= wp + IDX_W'(wr.cnt);
      count <= count + CNT_W'(wr.cnt) - CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      q[wp] <= wr.ev0;
    end
    if (wr.cnt == 2'd2) begin
      q[wp + IDX_W'(1)] <= wr.ev1;
    end
  end

endmodule

/* src/key_press_event_detector.sv */
// ---------------------------------------------------------------------------
// key_press_event_detector
// Timing: the events of a tick are offered on the event channel in the cycle
//   after the scan transfer if the queue was empty; a tick's two events go in turn.
// Throughput: one scan tick per cycle while the four-entry event queue has
//   two free slots; the queue drains one event transfer per cycle.
// Reset: synchronous; control state and registers return to defaults, the
//   edge FIFO memory is not cleared (no entry is read before it is written).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module key_press_event_detector #(
  parameter int EDGE_FIFO_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  // scan channel
  input  logic        scan_valid,
  output logic        scan_ready,
  input  logic [7:0]  scan_code,
  // event channel
  output logic        event_valid,
  input  logic        event_ready,
  output logic [2:0]  event_kind,
  output logic [7:0]  key_code,
  output logic        last_of_tick,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kped_pkg::*;

  // ---- configuration registers -------------------------------------------
  logic [3:0]  debounce_count;
  logic [15:0] long_press_count;
  logic [15:0] repeat_count;
  logic [7:0]  no_key_code;
  cfg_reg_t    reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count   <= DEBOUNCE_RST;
      long_press_count <= LONG_RST;
      repeat_count     <= REPEAT_RST;
      no_key_code      <= NO_KEY_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DEBOUNCE: debounce_count   <= pwdata[3:0];
        REG_LONG:     long_press_count <= pwdata[15:0];
        REG_REPEAT:   repeat_count     <= pwdata[15:0];
        REG_NO_KEY:   no_key_code      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = {28'd0, debounce_count};
      REG_LONG:     prdata = {16'd0, long_press_count};
      REG_REPEAT:   prdata = {16'd0, repeat_count};
      REG_NO_KEY:   prdata = {24'd0, no_key_code};
      default:      prdata = '0;
    endcase
  end

  // ---- debounce -----------------------------------------------------------
  // A code is stable once the streak of equal samples reaches debounce_count.
  // After each hit the streak restarts from zero on the next tick.
  logic       tick;
  logic       scan_restart;
  logic [3:0] scan_streak;
  logic [7:0] sample_history;
  logic [7:0] stable_key;
  logic [3:0] streak_inc;
  logic       match, hit, change;
  push_req_t  push;

  assign tick = scan_valid && scan_ready;

  always_comb begin
    match      = (scan_code == sample_history);
    streak_inc = (scan_restart ? 4'd0 : scan_streak) + 4'd1;
    hit        = match && (streak_inc >= debounce_count);
    change     = hit && (scan_code != stable_key);
    // release of the old key goes in ahead of the press of the new one
    push.a_en  = tick && change && (stable_key != no_key_code);
    push.a     = {1'b1, stable_key};
    push.b_en  = tick && change && (scan_code != no_key_code);
    push.b     = {1'b0, scan_code};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_restart   <= 1'b1;
      scan_streak    <= '0;
      sample_history <= NO_KEY_RST;
      stable_key     <= NO_KEY_RST;
    end else if (tick) begin
      scan_restart   <= hit;
      scan_streak    <= match ? streak_inc : 4'd0;
      sample_history <= scan_code;
      if (change) begin
        stable_key <= scan_code;
      end
    end
  end

  // ---- edge FIFO ----------------------------------------------------------
  // Memory backed; pushes of a tick are visible to the pop of the same tick.
  fifo_stat_t fstat;
  logic       pop;

  kped_edge_fifo #(
    .DEPTH (EDGE_FIFO_DEPTH)
  ) u_edge_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .stat (fstat)
  );

  // ---- event detector -----------------------------------------------------
  // At most one pop per tick: after a down event with more edges queued the
  // detector waits for the next tick. Hold count advances once per pass
  // through the wait states, i.e. every second tick while a key is held.
  phase_t      phase, phase_next;
  edge_t       held_event, held_next;
  logic [15:0] hold_counter, hold_next;
  logic [1:0]  ev_cnt;
  ev_kind_t    k0, k1;
  logic [7:0]  key0, key1;
  evq_wr_t     evq_wr;
  logic        room;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      held_event   <= {1'b1, NO_KEY_RST};
      hold_counter <= '0;
    end else if (tick) begin
      phase        <= phase_next;
      held_event   <= held_next;
      hold_counter <= hold_next;
    end
  end

  always_comb begin
    phase_next = phase;
    held_next  = held_event;
    hold_next  = hold_counter;
    pop        = 1'b0;
    ev_cnt     = 2'd0;
    k0         = EV_DOWN;
    k1         = EV_SHORT;
    key0       = held_event[7:0];
    key1       = held_event[7:0];
    case (phase)
      PH_IDLE, PH_WAIT_DOWN: begin
        if (phase == PH_IDLE) begin
          hold_next  = '0;
          phase_next = PH_WAIT_DOWN;
        end
        if (fstat.avail) begin
          pop       = tick;
          held_next = fstat.head;
          // a release while waiting for a press is discarded
          if (!fstat.head[REL_BIT]) begin
            ev_cnt     = 2'd1;
            k0         = EV_DOWN;
            key0       = fstat.head[7:0];
            phase_next = PH_WAIT_UP;
            if (!fstat.more) begin
              // nothing left to pop: straight into the first hold step
              hold_next  = hold_next + 16'd1;
              phase_next = PH_LONG_CHECK;
            end
          end
        end
      end
      PH_WAIT_UP: begin
        if (!fstat.avail) begin
          hold_next  = hold_counter + 16'd1;
          phase_next = PH_LONG_CHECK;
        end else begin
          pop       = tick;
          held_next = fstat.head;
          // a new press replaces the held key silently
          if (fstat.head[REL_BIT]) begin
            ev_cnt     = 2'd2;
            k0         = EV_UP;
            k1         = EV_SHORT;
            key0       = fstat.head[7:0];
            key1       = fstat.head[7:0];
            phase_next = PH_IDLE;
          end
        end
      end
      PH_LONG_CHECK: begin
        if (hold_counter < long_press_count) begin
          phase_next = PH_WAIT_UP;
        end else begin
          ev_cnt = 2'd1;
          k0     = EV_LONG;
          if (!fstat.avail) begin
            hold_next  = 16'd1;
            phase_next = PH_REPEAT_CHECK;
          end else begin
            pop        = tick;
            held_next  = fstat.head;
            hold_next  = '0;
            phase_next = PH_FINISH;
          end
        end
      end
      PH_WAIT_UP2: begin
        if (!fstat.avail) begin
          hold_next  = hold_counter + 16'd1;
          phase_next = PH_REPEAT_CHECK;
        end else begin
          pop        = tick;
          held_next  = fstat.head;
          phase_next = PH_FINISH;
        end
      end
      PH_REPEAT_CHECK: begin
        if (hold_counter >= repeat_count) begin
          hold_next = '0;
          ev_cnt    = 2'd1;
          k0        = EV_REPEAT;
        end
        phase_next = PH_WAIT_UP2;
      end
      PH_FINISH: begin
        if (held_event[REL_BIT]) begin
          ev_cnt     = 2'd1;
          k0         = EV_UP;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_WAIT_UP2;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    evq_wr.cnt      = tick ? ev_cnt : 2'd0;
    evq_wr.ev0.kind = k0;
    evq_wr.ev0.key  = key0;
    evq_wr.ev0.last = (ev_cnt == 2'd1);
    evq_wr.ev1.kind = k1;
    evq_wr.ev1.key  = key1;
    evq_wr.ev1.last = 1'b1;
  end

  // ---- event queue --------------------------------------------------------
  event_t evq_head;

  kped_evt_q u_evt_q (
    .clk         (clk),
    .rst         (rst),
    .wr          (evq_wr),
    .room        (room),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .head        (evq_head)
  );

  // a tick is taken only while two event slots are free
  assign scan_ready   = room;
  assign event_kind   = evq_head.kind;
  assign key_code     = evq_head.key;
  assign last_of_tick = evq_head.last;

  // ---- assertions ---------------------------------------------------------
  logic long_hit;

  assign long_hit = tick && (phase == PH_LONG_CHECK) && (hold_counter >= long_press_count);

  `KPED_ASSERT(a_pop_needs_entry, clk, rst, pop |-> fstat.avail, "pop from empty edge FIFO")
  `KPED_ASSERT(a_evt_shown, clk, rst, (evq_wr.cnt != 2'd0) |=> event_valid, "event not queued")
  `KPED_ASSERT(a_evt_only_on_tick, clk, rst, (evq_wr.cnt != 2'd0) |-> tick, "event without tick")
  `KPED_ASSERT(a_long_clr, clk, rst, long_hit |=> (hold_counter <= 16'd1), "hold not cleared")

endmodule
